// ----- src/block_buffer_cache_assert.svh -----
// Assertion macros for the block buffer cache RTL.
// Included by the modules that carry assertions; expects clk and rst_n in scope.
`ifndef BLOCK_BUFFER_CACHE_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_ASSERT_SVH
`ifndef SYNTH
`define BBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bbc: same-cycle check failed");
`define BBC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bbc: next-cycle check failed");
`else
`define BBC_ASSERT_IMP(label, ante, cons)
`define BBC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/bbc_pkg.sv -----
// Shared types and constants for the block buffer cache.
// No dependencies; imported by the cell, the sequencer, the top level and the testbench.
package bbc_pkg;

  localparam int ENTRY_W = 4;
  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FLAGS   = 2'd2
  } bbc_op_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_ALLOC     = 3'd1,
    ST_NONE_FREE = 3'd2,
    ST_RELEASED  = 3'd3,
    ST_REL_FREE  = 3'd4,
    ST_FLAGS     = 3'd5
  } bbc_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_COMMIT,
    S_DONE
  } bbc_state_t;

  // Contents of one cache entry as it travels round the ring
  typedef struct packed {
    logic [15:0] dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic        dirty;
    logic        upd;
  } bbc_ent_t;

  typedef struct packed {
    logic load;
    logic use_wrap;
  } bbc_cell_ctl_t;

  // shift: rotate the ring one place; partial: keep the tail, close the ring at the last-but-one
  typedef struct packed {
    logic shift;
    logic partial;
  } bbc_ring_ctl_t;

endpackage

// ----- src/bbc_if.sv -----
// Request and response channel interfaces for the block buffer cache.
// Plain valid/ready channels; no package dependency.
interface bbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] device;
  logic [31:0] block_number;
  logic [3:0]  entry;
  logic        set_uptodate;
  logic        set_dirty;

  modport source (output valid, op, device, block_number, entry, set_uptodate, set_dirty,
                  input ready);
  modport sink (input valid, op, device, block_number, entry, set_uptodate, set_dirty,
                output ready);
endinterface

interface bbc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] entry_out;
  logic       uptodate_out;
  logic       dirty_out;
  logic [7:0] count_out;

  modport source (output valid, status, entry_out, uptodate_out, dirty_out, count_out,
                  input ready);
  modport sink (input valid, status, entry_out, uptodate_out, dirty_out, count_out,
                output ready);
endinterface

// ----- src/block_buffer_cache.sv -----
// Top level of the block buffer cache: a ring of entry cells and its sequencer.
// Depends on bbc_pkg, bbc_if, bbc_cell and bbc_ctrl.
//
//   channel   direction  handshake       payload
//   in_req    sink       valid / ready   op, device, block_number, entry, set_uptodate, set_dirty
//   out_rsp   source     valid / ready   status, entry_out, uptodate_out, dirty_out, count_out
//
// One request at a time. The ring rotates once past its head cell to search it; hit,
// release, flag write and none-free then pass S_DECIDE and S_DONE to the response register;
// an allocation rotates the ring a second time in S_COMMIT to retag the victim and move it
// to the tail before S_DONE. in_req.ready is high only when idle.
// Synchronous reset restores free order 0 .. NUM_ENTRIES-1 with all entries cleared.
// A stalled response holds in its register; the next request may be taken meanwhile.
module block_buffer_cache #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  bbc_req_if.sink   in_req,
  bbc_rsp_if.source out_rsp
);
  import bbc_pkg::*;

  localparam int IDW = $clog2(NUM_ENTRIES);

  bbc_ent_t      cell_ent [NUM_ENTRIES];
  logic [IDW-1:0] cell_id [NUM_ENTRIES];
  bbc_ent_t      wrap_ent;
  bbc_ring_ctl_t ring_ctl;

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    bbc_cell_ctl_t ctl;
    bbc_ent_t      nb_ent;
    logic [IDW-1:0] nb_id;

    if (g == NUM_ENTRIES - 1) begin : g_tail
      assign ctl.load     = ring_ctl.shift && !ring_ctl.partial;
      assign ctl.use_wrap = 1'b1;
      assign nb_ent       = wrap_ent;
      assign nb_id        = cell_id[0];
    end else if (g == NUM_ENTRIES - 2) begin : g_last_but_one
      assign ctl.load     = ring_ctl.shift;
      assign ctl.use_wrap = ring_ctl.partial;
      assign nb_ent       = cell_ent[g+1];
      assign nb_id        = cell_id[g+1];
    end else begin : g_body
      assign ctl.load     = ring_ctl.shift;
      assign ctl.use_wrap = 1'b0;
      assign nb_ent       = cell_ent[g+1];
      assign nb_id        = cell_id[g+1];
    end

    bbc_cell #(
      .IDW      (IDW),
      .RESET_ID (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .nb_ent   (nb_ent),
      .nb_id    (nb_id),
      .wrap_ent (wrap_ent),
      .wrap_id  (cell_id[0]),
      .ent      (cell_ent[g]),
      .id       (cell_id[g])
    );
  end

  bbc_ctrl #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rsp  (out_rsp),
    .head_ent (cell_ent[0]),
    .head_id  (cell_id[0]),
    .wrap_ent (wrap_ent),
    .ring_ctl (ring_ctl)
  );

endmodule

// ----- src/bbc_cell.sv -----
// One ring cell: holds a cache entry and its index, loads from its neighbour or the wrap path.
// Depends on bbc_pkg.
module bbc_cell #(
  parameter int IDW      = 4,
  parameter int RESET_ID = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bbc_pkg::bbc_cell_ctl_t ctl,
  input  bbc_pkg::bbc_ent_t      nb_ent,
  input  logic [IDW-1:0]         nb_id,
  input  bbc_pkg::bbc_ent_t      wrap_ent,
  input  logic [IDW-1:0]         wrap_id,
  output bbc_pkg::bbc_ent_t      ent,
  output logic [IDW-1:0]         id
);
  import bbc_pkg::*;

  bbc_ent_t       ent_r, ent_nxt;
  logic [IDW-1:0] id_r, id_nxt;

  always_comb begin
    ent_nxt = ent_r;
    id_nxt  = id_r;
    if (ctl.load) begin
      ent_nxt = ctl.use_wrap ? wrap_ent : nb_ent;
      id_nxt  = ctl.use_wrap ? wrap_id : nb_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
      id_r  <= IDW'(RESET_ID);
    end else begin
      ent_r <= ent_nxt;
      id_r  <= id_nxt;
    end
  end

  assign ent = ent_r;
  assign id  = id_r;

endmodule

// ----- src/bbc_ctrl.sv -----
// Sequencer for the block buffer cache: request capture, head-of-ring evaluation,
// victim tracking and the response register. Depends on bbc_pkg, bbc_if and the assert header.
`include "block_buffer_cache_assert.svh"

module bbc_ctrl #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bbc_req_if.sink                         in_req,
  bbc_rsp_if.source                       out_rsp,
  input  bbc_pkg::bbc_ent_t               head_ent,
  input  logic [$clog2(NUM_ENTRIES)-1:0]  head_id,
  output bbc_pkg::bbc_ent_t               wrap_ent,
  output bbc_pkg::bbc_ring_ctl_t          ring_ctl
);
  import bbc_pkg::*;

  localparam int IDW = $clog2(NUM_ENTRIES);
  localparam int CW  = (IDW > ENTRY_W) ? IDW : ENTRY_W;
  localparam logic [IDW-1:0] LAST = IDW'(NUM_ENTRIES - 1);

  bbc_state_t        state_r, state_nxt;
  logic [IDW-1:0]    step_r, step_nxt;
  bbc_op_t           op_r, op_nxt;
  logic [15:0]       dev_r, dev_nxt;
  logic [31:0]       blk_r, blk_nxt;
  logic [3:0]        ent_r, ent_nxt;
  logic              su_r, su_nxt;
  logic              sd_r, sd_nxt;
  logic              hit_r, hit_nxt;
  logic              vfound_r, vfound_nxt;
  logic [IDW-1:0]    vpos_r, vpos_nxt;
  logic [32:0]       vbad_r, vbad_nxt;
  bbc_status_t       res_st_r, res_st_nxt;
  logic [3:0]        res_ent_r, res_ent_nxt;
  logic              res_upd_r, res_upd_nxt;
  logic              res_dirty_r, res_dirty_nxt;
  logic [7:0]        res_cnt_r, res_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  bbc_status_t       out_st_r, out_st_nxt;
  logic [3:0]        out_ent_r, out_ent_nxt;
  logic              out_upd_r, out_upd_nxt;
  logic              out_dirty_r, out_dirty_nxt;
  logic [7:0]        out_cnt_r, out_cnt_nxt;

  logic        known_op;
  logic        key_hit;
  logic        key_sel;
  logic        better;
  logic [32:0] head_bad;
  logic [3:0]  head_id4;

  assign known_op = (in_req.op == OP_GET) || (in_req.op == OP_RELEASE) ||
                    (in_req.op == OP_FLAGS);
  assign key_hit  = (op_r == OP_GET) && (dev_r != 16'd0) && !hit_r &&
                    (head_ent.dev == dev_r) && (head_ent.blk == blk_r);
  assign key_sel  = (op_r != OP_GET) && (CW'(head_id) == CW'(ent_r));
  assign head_bad = {1'b0, head_ent.blk} + 33'({head_ent.dirty, 1'b0});
  // strict compare keeps the first entry in free order among equals
  assign better   = (op_r == OP_GET) && (head_ent.cnt == 8'd0) &&
                    (!vfound_r || (head_bad < vbad_r));
  assign head_id4 = ENTRY_W'(CW'(head_id));

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    op_nxt        = op_r;
    dev_nxt       = dev_r;
    blk_nxt       = blk_r;
    ent_nxt       = ent_r;
    su_nxt        = su_r;
    sd_nxt        = sd_r;
    hit_nxt       = hit_r;
    vfound_nxt    = vfound_r;
    vpos_nxt      = vpos_r;
    vbad_nxt      = vbad_r;
    res_st_nxt    = res_st_r;
    res_ent_nxt   = res_ent_r;
    res_upd_nxt   = res_upd_r;
    res_dirty_nxt = res_dirty_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r;
    out_st_nxt    = out_st_r;
    out_ent_nxt   = out_ent_r;
    out_upd_nxt   = out_upd_r;
    out_dirty_nxt = out_dirty_r;
    out_cnt_nxt   = out_cnt_r;
    wrap_ent      = head_ent;
    ring_ctl      = '0;
    in_req.ready  = (state_r == S_IDLE);

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // unused op code: take the request and drop it
        if (in_req.valid && known_op) begin
          op_nxt        = bbc_op_t'(in_req.op);
          dev_nxt       = in_req.device;
          blk_nxt       = in_req.block_number;
          ent_nxt       = in_req.entry;
          su_nxt        = in_req.set_uptodate;
          sd_nxt        = in_req.set_dirty;
          step_nxt      = '0;
          hit_nxt       = 1'b0;
          vfound_nxt    = 1'b0;
          vbad_nxt      = '0;
          res_upd_nxt   = 1'b0;
          res_dirty_nxt = 1'b0;
          res_cnt_nxt   = 8'd0;
          case (in_req.op)
            OP_GET: begin
              res_st_nxt  = ST_NONE_FREE;
              res_ent_nxt = 4'd0;
            end
            OP_RELEASE: begin
              res_st_nxt  = ST_REL_FREE;
              res_ent_nxt = in_req.entry;
            end
            default: begin
              res_st_nxt  = ST_FLAGS;
              res_ent_nxt = in_req.entry;
            end
          endcase
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        ring_ctl.shift = 1'b1;
        if (key_hit) begin
          wrap_ent.cnt = (head_ent.cnt == CNT_MAX) ? CNT_MAX : head_ent.cnt + 8'd1;
          hit_nxt      = 1'b1;
          res_st_nxt   = ST_HIT;
        end
        if (key_sel && (op_r == OP_RELEASE)) begin
          if (head_ent.cnt != 8'd0) begin
            wrap_ent.cnt = head_ent.cnt - 8'd1;
            res_st_nxt   = ST_RELEASED;
          end else begin
            res_st_nxt   = ST_REL_FREE;
          end
        end
        if (key_sel && (op_r == OP_FLAGS)) begin
          wrap_ent.upd   = su_r;
          wrap_ent.dirty = sd_r;
          res_st_nxt     = ST_FLAGS;
        end
        if (key_hit || key_sel) begin
          res_ent_nxt   = head_id4;
          res_upd_nxt   = wrap_ent.upd;
          res_dirty_nxt = wrap_ent.dirty;
          res_cnt_nxt   = wrap_ent.cnt;
        end
        if (better) begin
          vfound_nxt = 1'b1;
          vpos_nxt   = step_r;
          vbad_nxt   = head_bad;
        end
        if (step_r == LAST) begin
          step_nxt  = '0;
          state_nxt = S_DECIDE;
        end else begin
          step_nxt  = step_r + IDW'(1);
        end
      end

      S_DECIDE: begin
        if ((op_r == OP_GET) && !hit_r && vfound_r) begin
          state_nxt = S_COMMIT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_COMMIT: begin
        // past the victim the tail holds it and the rest of the ring closes one short
        ring_ctl.shift   = 1'b1;
        ring_ctl.partial = (step_r > vpos_r);
        if (step_r == vpos_r) begin
          wrap_ent.dev   = dev_r;
          wrap_ent.blk   = blk_r;
          wrap_ent.cnt   = 8'd1;
          wrap_ent.dirty = 1'b0;
          wrap_ent.upd   = 1'b0;
          res_st_nxt     = ST_ALLOC;
          res_ent_nxt    = head_id4;
          res_upd_nxt    = 1'b0;
          res_dirty_nxt  = 1'b0;
          res_cnt_nxt    = 8'd1;
        end
        if (step_r == LAST) begin
          step_nxt  = '0;
          state_nxt = S_DONE;
        end else begin
          step_nxt  = step_r + IDW'(1);
        end
      end

      S_DONE: begin
        // hold the result until the response register is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_ent_nxt   = res_ent_r;
          out_upd_nxt   = res_upd_r;
          out_dirty_nxt = res_dirty_r;
          out_cnt_nxt   = res_cnt_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      hit_r       <= 1'b0;
      vfound_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      hit_r       <= hit_nxt;
      vfound_r    <= vfound_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    dev_r       <= dev_nxt;
    blk_r       <= blk_nxt;
    ent_r       <= ent_nxt;
    su_r        <= su_nxt;
    sd_r        <= sd_nxt;
    vpos_r      <= vpos_nxt;
    vbad_r      <= vbad_nxt;
    res_st_r    <= res_st_nxt;
    res_ent_r   <= res_ent_nxt;
    res_upd_r   <= res_upd_nxt;
    res_dirty_r <= res_dirty_nxt;
    res_cnt_r   <= res_cnt_nxt;
    out_st_r    <= out_st_nxt;
    out_ent_r   <= out_ent_nxt;
    out_upd_r   <= out_upd_nxt;
    out_dirty_r <= out_dirty_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_st_r;
  assign out_rsp.entry_out    = out_ent_r;
  assign out_rsp.uptodate_out = out_upd_r;
  assign out_rsp.dirty_out    = out_dirty_r;
  assign out_rsp.count_out    = out_cnt_r;

  `BBC_ASSERT_IMP(a_commit_needs_victim, state_r == S_COMMIT, (op_r == OP_GET) && !hit_r && vfound_r)
  `BBC_ASSERT_IMP(a_hit_has_device, hit_r, dev_r != 16'd0)
  `BBC_ASSERT_NXT(a_scan_ends, (state_r == S_SCAN) && (step_r == LAST), state_r == S_DECIDE)
  `BBC_ASSERT_NXT(a_done_loads, (state_r == S_DONE) && (!out_valid_r || out_rsp.ready), out_valid_r && (state_r == S_IDLE))

endmodule

// ----- test/block_buffer_cache_test.sv -----
// Self-checking testbench for block_buffer_cache: directed table, a count-saturation run, then random requests.
// Takes each response from the table or predicts it from its own copy of the cache directory, and checks it in order.
// Depends on bbc_pkg, bbc_if and the block_buffer_cache RTL.
module block_buffer_cache_test;
  import bbc_pkg::*;

  localparam int ENTRIES = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 800;
  localparam int HAMMER_ITEMS = 258;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] dev;
    logic [31:0] blk;
    logic [3:0]  ent;
    logic        upd;
    logic        dirty;
  } cache_req_t;

  typedef struct packed {
    bbc_status_t status;
    logic [3:0]  ent;
    logic        upd;
    logic        dirty;
    logic [7:0]  cnt;
  } cache_rsp_t;

  typedef struct {
    cache_req_t req;
    bit         typed;
    cache_rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  bbc_req_if req_ch ();
  bbc_rsp_if rsp_ch ();

  block_buffer_cache #(.NUM_ENTRIES(ENTRIES)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // Predicted directory contents
  logic [15:0] line_dev   [ENTRIES];
  logic [31:0] line_blk   [ENTRIES];
  logic [7:0]  line_refs  [ENTRIES];
  logic        line_dirty [ENTRIES];
  logic        line_upd   [ENTRIES];
  logic [3:0]  lru_order  [ENTRIES];

  cache_rsp_t pending_replies [$];
  plan_row_t  plan_q [$];
  int         n_mismatch = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic cache_rsp_t entry_view(bbc_status_t st, logic [3:0] idx);
    cache_rsp_t v;
    v.status = st;
    v.ent    = idx;
    v.upd    = line_upd[idx];
    v.dirty  = line_dirty[idx];
    v.cnt    = line_refs[idx];
    return v;
  endfunction

  // Apply one request to the predicted directory; returns 0 when no response follows
  function automatic bit cache_apply(input cache_req_t r, output cache_rsp_t res);
    logic [33:0] badness;
    logic [33:0] best_bad;
    logic [3:0]  cand;
    logic [3:0]  best;
    bit          found;
    int          pos;
    res = '0;
    best = '0;
    best_bad = '0;
    found = 1'b0;
    pos = 0;
    if (r.op == OP_GET) begin
      if (r.dev != 16'd0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_dev[i] == r.dev && line_blk[i] == r.blk) begin
            if (line_refs[i] != CNT_MAX) line_refs[i]++;
            res = entry_view(ST_HIT, 4'(i));
            return 1'b1;
          end
        end
      end
      // walk from the head; first entry of least badness wins, zero ends the walk
      for (int p = 0; p < ENTRIES; p++) begin
        cand = lru_order[p];
        if (line_refs[cand] != 8'd0) continue;
        badness = {2'b00, line_blk[cand]} + {32'd0, line_dirty[cand], 1'b0};
        if (!found || best_bad > badness) begin
          found = 1'b1;
          best = cand;
          best_bad = badness;
          if (badness == 34'd0) break;
        end
      end
      if (!found) begin
        res.status = ST_NONE_FREE;
        return 1'b1;
      end
      line_refs[best]  = 8'd1;
      line_dirty[best] = 1'b0;
      line_upd[best]   = 1'b0;
      line_dev[best]   = r.dev;
      line_blk[best]   = r.blk;
      for (int p = 0; p < ENTRIES; p++) begin
        if (lru_order[p] == best) begin
          pos = p;
          break;
        end
      end
      for (int p = pos; p < ENTRIES - 1; p++) lru_order[p] = lru_order[p + 1];
      lru_order[ENTRIES - 1] = best;
      res = entry_view(ST_ALLOC, best);
      return 1'b1;
    end else if (r.op == OP_RELEASE) begin
      if (line_refs[r.ent] == 8'd0) begin
        res = entry_view(ST_REL_FREE, r.ent);
      end else begin
        line_refs[r.ent]--;
        res = entry_view(ST_RELEASED, r.ent);
      end
      return 1'b1;
    end else if (r.op == OP_FLAGS) begin
      line_upd[r.ent]   = r.upd;
      line_dirty[r.ent] = r.dirty;
      res = entry_view(ST_FLAGS, r.ent);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void plan(logic [1:0] op, logic [15:0] dev, logic [31:0] blk,
                               logic [3:0] ent, logic upd, logic dirty, bit typed,
                               bbc_status_t st, logic [3:0] e_ent, logic e_upd,
                               logic e_dirty, logic [7:0] e_cnt);
    plan_row_t row;
    row.req   = '{op: op, dev: dev, blk: blk, ent: ent, upd: upd, dirty: dirty};
    row.typed = typed;
    row.want  = '{status: st, ent: e_ent, upd: e_upd, dirty: e_dirty, cnt: e_cnt};
    plan_q.push_back(row);
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic cache_req_t random_request();
    cache_req_t r;
    int k;
    int start;
    r.op    = 2'($urandom_range(3));
    r.dev   = 16'($urandom_range(65535));
    r.blk   = $urandom;
    r.ent   = 4'($urandom_range(15));
    r.upd   = 1'($urandom_range(1));
    r.dirty = 1'($urandom_range(1));
    k = $urandom_range(99);
    if (k < 45) begin
      r.op = OP_GET;
      // a small pool of tags makes hits and ties common
      k = $urandom_range(99);
      if (k < 80) begin
        case ($urandom_range(3))
          0: r.dev = 16'd1;
          1: r.dev = 16'd2;
          2: r.dev = 16'd3;
          default: r.dev = 16'hFFFF;
        endcase
      end else if (k < 88) begin
        r.dev = 16'd0;
      end
      if ($urandom_range(99) < 75) begin
        case ($urandom_range(6))
          0: r.blk = 32'd0;
          1: r.blk = 32'd1;
          2: r.blk = 32'd2;
          3: r.blk = 32'd3;
          4: r.blk = 32'd5;
          5: r.blk = 32'hFFFF_FFFE;
          default: r.blk = 32'hFFFF_FFFF;
        endcase
      end
    end else if (k < 78) begin
      r.op = OP_RELEASE;
      if ($urandom_range(99) < 75) begin
        start = $urandom_range(ENTRIES - 1);
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_refs[(start + i) % ENTRIES] != 8'd0) begin
            r.ent = 4'((start + i) % ENTRIES);
            break;
          end
        end
      end
    end else if (k < 96) begin
      r.op = OP_FLAGS;
    end else begin
      r.op = OP_UNUSED;
    end
    return r;
  endfunction

  task automatic send(input cache_req_t r, input bit typed, input cache_rsp_t want);
    cache_rsp_t guess;
    @(negedge clk);
    req_ch.valid        <= 1'b1;
    req_ch.op           <= r.op;
    req_ch.device       <= r.dev;
    req_ch.block_number <= r.blk;
    req_ch.entry        <= r.ent;
    req_ch.set_uptodate <= r.upd;
    req_ch.set_dirty    <= r.dirty;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (cache_apply(r, guess)) pending_replies.push_back(typed ? want : guess);
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // hold requests back until every outstanding response is in
  task automatic drain();
    idle(1);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      n_mismatch++;
    end
  endfunction

  always @(posedge clk) begin
    cache_rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected response: expected none, got status %0d entry %0d",
                 $time, rsp_ch.status, rsp_ch.entry_out);
        n_mismatch++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("entry_out", want.ent, rsp_ch.entry_out);
        check_field("uptodate_out", want.upd, rsp_ch.uptodate_out);
        check_field("dirty_out", want.dirty, rsp_ch.dirty_out);
        check_field("count_out", want.cnt, rsp_ch.count_out);
      end
    end
  end

  // Response side: random stalls, mostly short, now and then long or absent
  initial begin
    bit hold;
    int len;
    rsp_ch.ready = 1'b0;
    forever begin
      hold = $urandom_range(99) < 65;
      if (hold) len = ($urandom_range(99) < 10) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      else len = ($urandom_range(99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      @(negedge clk);
      rsp_ch.ready <= hold;
      repeat (len - 1) @(negedge clk);
    end
  end

  initial begin
    cache_req_t r;
    bit all_busy;
    bit burst;
    int sent;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op = OP_GET;
    req_ch.device = '0;
    req_ch.block_number = '0;
    req_ch.entry = '0;
    req_ch.set_uptodate = 1'b0;
    req_ch.set_dirty = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      line_dev[i]   = '0;
      line_blk[i]   = '0;
      line_refs[i]  = '0;
      line_dirty[i] = 1'b0;
      line_upd[i]   = 1'b0;
      lru_order[i]  = 4'(i);
    end

    //    op          device       block          ent upd drt typed status     ent upd drt cnt
    plan(OP_RELEASE, 16'd0,      32'd0,         4'd5,  0, 0, 1, ST_REL_FREE, 4'd5,  0, 0, 8'd0);
    plan(OP_FLAGS,   16'd0,      32'd0,         4'd15, 1, 1, 1, ST_FLAGS,    4'd15, 1, 1, 8'd0);
    plan(OP_GET,     16'hFFFF,   32'hFFFF_FFFF, 4'd0,  0, 0, 1, ST_ALLOC,    4'd0,  0, 0, 8'd1);
    plan(OP_GET,     16'hFFFF,   32'hFFFF_FFFF, 4'd0,  0, 0, 1, ST_HIT,      4'd0,  0, 0, 8'd2);
    plan(OP_GET,     16'd0,      32'hFFFF_FFFF, 4'd0,  0, 0, 1, ST_ALLOC,    4'd1,  0, 0, 8'd1);
    plan(OP_GET,     16'd0,      32'hFFFF_FFFF, 4'd0,  0, 0, 1, ST_ALLOC,    4'd2,  0, 0, 8'd1);
    plan(OP_RELEASE, 16'd0,      32'd0,         4'd0,  0, 0, 1, ST_RELEASED, 4'd0,  0, 0, 8'd1);
    plan(OP_RELEASE, 16'd0,      32'd0,         4'd0,  0, 0, 1, ST_RELEASED, 4'd0,  0, 0, 8'd0);
    plan(OP_RELEASE, 16'd0,      32'd0,         4'd0,  0, 0, 1, ST_REL_FREE, 4'd0,  0, 0, 8'd0);
    plan(OP_FLAGS,   16'd0,      32'd0,         4'd3,  1, 0, 1, ST_FLAGS,    4'd3,  1, 0, 8'd0);
    plan(OP_FLAGS,   16'd0,      32'd0,         4'd4,  0, 1, 1, ST_FLAGS,    4'd4,  0, 1, 8'd0);
    plan(OP_GET,     16'd1,      32'd0,         4'd0,  0, 0, 1, ST_ALLOC,    4'd3,  0, 0, 8'd1);
    plan(OP_UNUSED,  16'hFFFF,   32'hFFFF_FFFF, 4'd15, 1, 1, 0, ST_HIT,      4'd0,  0, 0, 8'd0);
    plan(OP_GET,     16'd1,      32'd0,         4'd0,  0, 0, 1, ST_HIT,      4'd3,  0, 0, 8'd2);
    // take every remaining entry, dirty ones and the far block included
    for (int k = 0; k < 13; k++)
      plan(OP_GET,   16'd2,      32'(10 + k),   4'd0,  0, 0, 0, ST_HIT,      4'd0,  0, 0, 8'd0);
    plan(OP_GET,     16'd2,      32'd99,        4'd0,  0, 0, 1, ST_NONE_FREE, 4'd0, 0, 0, 8'd0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan_q[i]) begin
      send(plan_q[i].req, plan_q[i].typed, plan_q[i].want);
      idle(gap_len());
    end
    drain();

    // drive one entry's count into saturation; free an entry first if none is left
    all_busy = 1'b1;
    foreach (line_refs[i]) if (line_refs[i] == 8'd0) all_busy = 1'b0;
    r = '{op: OP_RELEASE, dev: 16'd0, blk: 32'd0, ent: 4'd0, upd: 1'b0, dirty: 1'b0};
    while (all_busy && line_refs[0] != 8'd0) send(r, 1'b0, '0);
    r = '{op: OP_GET, dev: 16'h5A5A, blk: $urandom, ent: 4'd0, upd: 1'b0, dirty: 1'b0};
    repeat (HAMMER_ITEMS) begin
      send(r, 1'b0, '0);
      idle(gap_len());
    end

    sent = 0;
    burst = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      r = random_request();
      send(r, 1'b0, '0);
      if (r.op != OP_UNUSED) begin
        sent++;
        if (sent % 50 == 0) burst = ($urandom_range(4) == 0);
        if (sent % 150 == 0) drain();
      end
      if (!burst) idle(gap_len());
    end

    drain();
    repeat (2 * ENTRIES + 8) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/bbc_pkg.sv
src/bbc_if.sv
src/bbc_cell.sv
src/bbc_ctrl.sv
src/block_buffer_cache.sv
test/block_buffer_cache_test.sv
